// ----- design/sds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the sorted date set unit.
// Table depth, field widths, operation codes and the controller commands.
// ----------------------------------------------------------------------------
package sds_pkg;

	// Table depth, field widths and the count and select widths that follow from them.
	localparam int DEPTH  = 64;
	localparam int KEY_W  = 27;
	localparam int MODE_W = 3;
	localparam int RANK_W = 6;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SEL_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;

	// Operation codes carried in the mode field.
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 3'd0,
		MODE_FIRST  = 3'd1,
		MODE_LAST   = 3'd2,
		MODE_PREV   = 3'd3,
		MODE_NEXT   = 3'd4,
		MODE_RANK   = 3'd5
	} mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the input beat and run the compare
		logic commit;  // update the table and load the result register
	} sds_cmd_t;

endpackage

// ----- design/sds_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_ctrl: controller of the sorted date set unit.
// Sequences each beat through compare and commit, and owns the output valid.
// ----------------------------------------------------------------------------
module sds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output sds_pkg::sds_cmd_t cmd
);
	import sds_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	// The result register can take a new beat when empty or being drained.
	assign slot_free  = !out_valid_q || !out_stall;
	assign in_stall   = (state_q == ST_BUSY);
	assign out_valid  = out_valid_q;
	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.commit = (state_q == ST_BUSY) && slot_free;

	// State and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_BUSY;
					end
					if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_BUSY: begin
					if (slot_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result appears only as the end of a busy cycle.
	a_rise_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_BUSY))
		else $error("out_valid rose without a commit");

	// With an empty result register a busy beat finishes at once.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY) && !out_valid_q |=> (state_q == ST_IDLE))
		else $error("busy beat did not finish with a free result slot");

	// Load and commit never coincide.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.commit))
		else $error("load and commit in the same cycle");

endmodule

// ----- design/sds_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_datapath: key table and result logic of the sorted date set unit.
// A row of key cells compared in parallel, shifted in place on insert.
// ----------------------------------------------------------------------------
module sds_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sds_pkg::sds_cmd_t         cmd,
	input  logic [sds_pkg::MODE_W-1:0] mode,
	input  logic [sds_pkg::KEY_W-1:0]  key,
	input  logic [sds_pkg::RANK_W-1:0] rank,
	output logic [sds_pkg::KEY_W-1:0]  value,
	output logic                      found,
	output logic                      full_res
);
	import sds_pkg::*;

	logic [KEY_W-1:0] cells_q [DEPTH];
	logic [CNT_W-1:0] count_q;

	mode_t            mode_s1;
	logic [KEY_W-1:0] key_s1;
	logic [DEPTH-1:0] lt_s1;
	logic [DEPTH-1:0] sel_s1;
	logic             present_s1;

	logic [DEPTH-1:0] live;
	logic [DEPTH-1:0] lt;
	logic [DEPTH-1:0] eq;
	logic [DEPTH-1:0] sel;

	logic [KEY_W-1:0] pick;
	logic             table_full;

	logic [KEY_W-1:0] value_q;
	logic             found_q;
	logic             full_q;

	// Per-cell compare of the incoming key against the stored keys.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			live[i] = CNT_W'(i) < count_q;
			lt[i]   = live[i] && (cells_q[i] < key);
			eq[i]   = live[i] && (cells_q[i] == key);
		end
	end

	// One-hot choice of the cell a query reads.
	always_comb begin
		sel = '0;
		unique case (mode)
			MODE_FIRST: begin
				sel[0] = live[0];
			end
			MODE_LAST: begin
				for (int i = 0; i < DEPTH; i++) begin
					sel[i] = (CNT_W'(i + 1) == count_q);
				end
			end
			MODE_PREV: begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					sel[i] = eq[i+1];
				end
			end
			MODE_NEXT: begin
				for (int i = 1; i < DEPTH; i++) begin
					sel[i] = eq[i-1] && live[i];
				end
			end
			MODE_RANK: begin
				for (int i = 0; i < DEPTH; i++) begin
					sel[i] = live[i] && (SEL_W'(i) == SEL_W'(rank));
				end
			end
			default: begin
				sel = '0;
			end
		endcase
	end

	// Compare stage registers, loaded with the accepted beat.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_s1    <= mode_t'(mode);
			key_s1     <= key;
			lt_s1      <= lt;
			sel_s1     <= sel;
			present_s1 <= |eq;
		end
	end

	// AND-OR read of the selected cell.
	always_comb begin
		pick = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pick = pick | (cells_q[i] & {KEY_W{sel_s1[i]}});
		end
	end

	assign table_full = (count_q == CNT_W'(DEPTH));

	// Key cells: on insert the cell at the slot takes the new key and every cell above it takes its lower neighbor.
	always_ff @(posedge clk) begin
		if (cmd.commit && (mode_s1 == MODE_INSERT) && !present_s1 && !table_full) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!lt_s1[i]) begin
					if (i == 0) begin
						cells_q[i] <= key_s1;
					end else if (lt_s1[i-1]) begin
						cells_q[i] <= key_s1;
					end else begin
						cells_q[i] <= cells_q[i-1];
					end
				end
			end
		end
	end

	// Key count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit && (mode_s1 == MODE_INSERT) && !present_s1
				&& !table_full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (mode_s1 == MODE_INSERT) begin
				value_q <= (present_s1 || !table_full) ? key_s1 : '0;
				found_q <= present_s1 || !table_full;
				full_q  <= !present_s1 && table_full;
			end else begin
				value_q <= pick;
				found_q <= |sel_s1;
				full_q  <= 1'b0;
			end
		end
	end

	assign value    = value_q;
	assign found    = found_q;
	assign full_res = full_q;

	// The count never passes the table depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("key count above table depth");

	// The count only grows, one key at a time.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("key count changed by other than one");

	// A query reads at most one cell.
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $onehot0(sel_s1))
		else $error("query selected more than one cell");

endmodule

// ----- design/sorted_date_set_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_date_set_unit: ordered set of distinct date keys.
// Insert, first, last, previous, next and by-rank queries, one result a beat.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------
//   in      | in_valid / in_stall | mode, key, rank
//   out     | out_valid/out_stall | value, found, full_res
//
// Each beat first compares the key against all cells, registering the result,
// then shifts the cells in place or reads the chosen cell into the result.
// A held result only delays the commit; the next beat is taken once the
// current one is committed. Reset empties the set at once; no sweep.
// ----------------------------------------------------------------------------
module sorted_date_set_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [sds_pkg::MODE_W-1:0] mode,
	input  logic [sds_pkg::KEY_W-1:0]  key,
	input  logic [sds_pkg::RANK_W-1:0] rank,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [sds_pkg::KEY_W-1:0]  value,
	output logic                       found,
	output logic                       full_res
);
	import sds_pkg::*;

	sds_cmd_t cmd;

	// Beat sequencing.
	sds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Key table and result.
	sds_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mode     (mode),
		.key      (key),
		.rank     (rank),
		.value    (value),
		.found    (found),
		.full_res (full_res)
	);

endmodule

// ----- tb/sorted_date_set_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_date_set_checker: result checker for the sorted date set unit.
// Watches both channels, keeps its own ordered table of date keys, predicts
// the result of every accepted input beat and compares each accepted output
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_date_set_checker
	import sds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [KEY_W-1:0]  key,
	input  logic [RANK_W-1:0] rank,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [KEY_W-1:0]  value,
	input  logic              found,
	input  logic              full_res,
	output int                errors,
	output int                outstanding,
	output int                results_checked,
	output int                dropped_inserts
);

	typedef struct packed {
		logic [KEY_W-1:0] value;
		logic             found;
		logic             full_res;
	} date_result_t;

	// Shadow copy of the ordered key table.
	logic [KEY_W-1:0] table_keys [DEPTH];
	int               table_count;

	// Predicted results, oldest first.
	date_result_t     expected_results [$];

	// Applies one operation to the shadow table and returns its result.
	function automatic date_result_t apply_date_op(logic [MODE_W-1:0] op,
			logic [KEY_W-1:0] k, logic [RANK_W-1:0] r);
		date_result_t res;
		int           below;
		bit           present;
		res   = '0;
		below = 0;
		for (int i = 0; i < table_count; i++)
			if (table_keys[i] < k)
				below++;
		present = (below < table_count) && (table_keys[below] == k);
		case (op)
			MODE_INSERT: begin
				if (present) begin
					res.value = k;
					res.found = 1'b1;
				end else if (table_count >= DEPTH) begin
					res.full_res = 1'b1;
				end else begin
					for (int i = table_count; i > below; i--)
						table_keys[i] = table_keys[i-1];
					table_keys[below] = k;
					table_count++;
					res.value = k;
					res.found = 1'b1;
				end
			end
			MODE_FIRST: begin
				if (table_count > 0) begin
					res.value = table_keys[0];
					res.found = 1'b1;
				end
			end
			MODE_LAST: begin
				if (table_count > 0) begin
					res.value = table_keys[table_count-1];
					res.found = 1'b1;
				end
			end
			MODE_PREV: begin
				if (present && below > 0) begin
					res.value = table_keys[below-1];
					res.found = 1'b1;
				end
			end
			MODE_NEXT: begin
				if (present && below + 1 < table_count) begin
					res.value = table_keys[below+1];
					res.found = 1'b1;
				end
			end
			MODE_RANK: begin
				if (int'(r) < table_count) begin
					res.value = table_keys[r];
					res.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Output beats are checked before the input beat of the same edge is
	// predicted; the block cannot answer a beat on the edge that takes it.
	always @(posedge clk or negedge arst_n) begin
		date_result_t want;
		if (!arst_n) begin
			table_count = 0;
			expected_results.delete();
			errors          = 0;
			results_checked = 0;
			dropped_inserts = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no prediction pending: value %0d", value);
					errors++;
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (value !== want.value) begin
						$error("value mismatch: expected %0d, actual %0d", want.value, value);
						errors++;
					end
					if (found !== want.found) begin
						$error("found mismatch: expected %0b, actual %0b", want.found, found);
						errors++;
					end
					if (full_res !== want.full_res) begin
						$error("full_res mismatch: expected %0b, actual %0b",
							want.full_res, full_res);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = apply_date_op(mode, key, rank);
				if (want.full_res)
					dropped_inserts++;
				expected_results.push_back(want);
			end
		end
		outstanding = expected_results.size();
	end

endmodule

// ----- tb/sorted_date_set_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_date_set_unit_tb: top of the sorted date set unit testbench.
// Drives directed corner beats and then random operation streams with random
// gaps and output stalls, including one long output hold-off; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_date_set_unit_tb;
	import sds_pkg::*;

	localparam int               RANDOM_BEATS = 1650;
	localparam int               HOLD_CYCLES  = 300;
	localparam int               IDLE_LIMIT   = 2000;
	localparam logic [KEY_W-1:0] MAX_KEY      = {KEY_W{1'b1}};
	localparam logic [KEY_W-1:0] LAST_DATE    = 27'd99991231;
	localparam logic [KEY_W-1:0] MID_DATE     = 27'd20240229;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  key;
	logic [RANK_W-1:0] rank;
	logic              out_valid;
	logic              out_stall;
	logic [KEY_W-1:0]  value;
	logic              found;
	logic              full_res;
	int                errors;
	int                outstanding;
	int                results_checked;
	int                dropped_inserts;

	// Stretches with no idling on either side.
	bit                calm;
	int                beats_sent;
	int                idle_cycles;
	logic [KEY_W-1:0]  inserted_keys [$];

	sorted_date_set_unit u_dut (.*);

	sorted_date_set_checker u_check (.*);

	// 2 ns clock.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: ends the run when no beat moves for too long.
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random stall per beat, one long hold-off partway through.
	initial begin : result_sink
		int wait_cycles;
		int taken;
		taken     = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (taken == 700) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				wait_cycles = calm ? 0 : $urandom_range(0, 7);
				if (wait_cycles > 0) begin
					out_stall = 1'b1;
					repeat (wait_cycles) @(negedge clk);
				end
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Offers one input beat after a random gap and holds it until taken.
	task automatic send_beat(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
			input logic [RANK_W-1:0] r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		mode     = m;
		key      = k;
		rank     = r;
		if (m == MODE_INSERT && inserted_keys.size() < 256)
			inserted_keys.push_back(k);
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	function automatic logic [KEY_W-1:0] random_date();
		return KEY_W'($urandom_range(1900, 2099) * 10000 + $urandom_range(1, 12) * 100
			+ $urandom_range(1, 31));
	endfunction

	// Weighted choice of operation; the unused codes come up rarely.
	function automatic logic [MODE_W-1:0] pick_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 25)
			return MODE_INSERT;
		else if (roll < 33)
			return MODE_FIRST;
		else if (roll < 41)
			return MODE_LAST;
		else if (roll < 61)
			return MODE_PREV;
		else if (roll < 81)
			return MODE_NEXT;
		else if (roll < 97)
			return MODE_RANK;
		return MODE_W'($urandom_range(6, 7));
	endfunction

	// Mostly keys already offered, so neighbor queries hit; some fresh dates
	// and some arbitrary 27-bit values.
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55 && inserted_keys.size() > 0)
			return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
		else if (roll < 85)
			return random_date();
		return KEY_W'($urandom());
	endfunction

	initial begin
		logic [MODE_W-1:0] op;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_FIRST;
		key        = '0;
		rank       = '0;
		calm       = 1'b0;
		beats_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Queries on the empty set.
		send_beat(MODE_FIRST, '0, '0);
		send_beat(MODE_LAST, '0, '0);
		send_beat(MODE_PREV, MID_DATE, '0);
		send_beat(MODE_NEXT, MID_DATE, '0);
		send_beat(MODE_RANK, '0, '0);
		send_beat(MODE_RANK, '0, '1);
		// Extreme keys, a key above the date range and a repeated insert.
		send_beat(MODE_INSERT, MAX_KEY, '0);
		send_beat(MODE_INSERT, '0, '0);
		send_beat(MODE_INSERT, LAST_DATE, '0);
		send_beat(MODE_INSERT, '0, '0);
		send_beat(MODE_FIRST, '0, '0);
		send_beat(MODE_LAST, '0, '0);
		// Neighbors at the ends, in the middle and of an absent key.
		send_beat(MODE_PREV, '0, '0);
		send_beat(MODE_NEXT, MAX_KEY, '0);
		send_beat(MODE_PREV, MAX_KEY, '0);
		send_beat(MODE_NEXT, '0, '0);
		send_beat(MODE_PREV, MID_DATE, '0);
		send_beat(MODE_NEXT, MID_DATE, '0);
		// Ranks inside and beyond the count, then the unused codes.
		send_beat(MODE_RANK, '0, 6'd0);
		send_beat(MODE_RANK, '0, 6'd2);
		send_beat(MODE_RANK, '0, 6'd3);
		send_beat(MODE_RANK, '0, '1);
		send_beat(3'd6, MID_DATE, 6'd1);
		send_beat(3'd7, MAX_KEY, '1);

		// Random traffic; the table fills early, so dropped inserts follow.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			calm = (n >= 300 && n < 400) || (n >= 1200 && n < 1300);
			if ($urandom_range(0, 99) < 5)
				send_beat(MODE_W'($urandom_range(0, 7)), KEY_W'($urandom()),
					RANK_W'($urandom()));
			else begin
				op = pick_op();
				send_beat(op, pick_key(), RANK_W'($urandom_range(0, 63)));
			end
		end
		calm = 1'b0;
		@(negedge clk);
		in_valid = 1'b0;

		// Drain, then keep watching for any stray result.
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Run covered %0d input beats and %0d checked results,", beats_sent,
			results_checked);
		$display("with %0d inserts dropped on a full table and one long output hold-off.",
			dropped_inserts);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
